[hdl/stdf_pkg.sv]
`default_nettype none
package stdf_pkg;

  localparam logic [7:0] BYTE_STX   = 8'h02;
  localparam logic [7:0] BYTE_ETX   = 8'h03;
  localparam logic [7:0] ID_A       = 8'h41;
  localparam logic [7:0] ID_B       = 8'h42;
  localparam logic [7:0] CHR_PLUS   = 8'h2B;
  localparam logic [7:0] CHR_MINUS  = 8'h2D;
  localparam logic [7:0] CHR_ZERO   = 8'h30;
  localparam logic [7:0] CHR_NINE   = 8'h39;
  localparam logic [7:0] CHR_SPACE  = 8'h20;
  localparam logic [7:0] CHR_TAB    = 8'h09;
  localparam logic [7:0] CHR_CR     = 8'h0D;
  localparam logic [7:0] CORR_RESET = 8'hCE;

  localparam logic CFG_CORR_A = 1'b0;
  localparam logic CFG_CORR_B = 1'b1;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_STX  = 2'd1,
    KIND_ETX  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } q_entry_t;

  typedef enum logic [2:0] {
    STAT_NONE     = 3'd0,
    STAT_GOOD     = 3'd1,
    STAT_CHECKSUM = 3'd2,
    STAT_OVERFLOW = 3'd3,
    STAT_EMPTY    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    UPD_NONE = 2'd0,
    UPD_A    = 2'd1,
    UPD_B    = 2'd2
  } upd_t;

  typedef struct packed {
    status_t status;
    logic    restart;
    upd_t    updated;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_READ   = 2'd1,
    ST_EVAL   = 2'd2,
    ST_FINISH = 2'd3
  } back_state_t;

endpackage
`default_nettype wire

[hdl/stdf_ram.sv]
`default_nettype none
module stdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 6
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

[hdl/stdf_front.sv]
`default_nettype none
module stdf_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        in_rx_byte,
  output logic                   q_valid,
  output stdf_pkg::q_entry_t     q_head,
  input  wire logic              q_pop
);
  import stdf_pkg::*;

  q_entry_t   slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  q_entry_t   entry;

  // classify by byte value only, frame context is tracked behind the queue
  always_comb begin
    entry.data = in_rx_byte;
    if (in_rx_byte == BYTE_STX) begin
      entry.kind = KIND_STX;
    end else if (in_rx_byte == BYTE_ETX) begin
      entry.kind = KIND_ETX;
    end else begin
      entry.kind = KIND_DATA;
    end
  end

  assign in_ready = (count_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != 2'd0);
  assign q_head   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= entry;
    end
  end

endmodule
`default_nettype wire

[hdl/stdf_back.sv]
`default_nettype none
module stdf_back #(
  parameter int PAYLOAD_DEPTH = 6
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  input  wire stdf_pkg::q_entry_t q_head,
  output logic                    q_pop,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [7:0]         cfg_data,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output stdf_pkg::result_t       res,
  output logic [7:0]              reading_a,
  output logic [7:0]              reading_b
);
  import stdf_pkg::*;

  localparam int AW = $clog2(PAYLOAD_DEPTH);
  localparam int FW = $clog2(PAYLOAD_DEPTH + 1);
  localparam logic [FW-1:0] FILL_MAX = FW'(PAYLOAD_DEPTH);
  localparam logic [FW-1:0] FILL_ONE = FW'(1);
  localparam logic [FW-1:0] FILL_TWO = FW'(2);

  back_state_t state_r, state_nxt;
  logic          in_frame_r, in_frame_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [7:0]    sum_r, sum_nxt;
  logic [7:0]    first_r, first_nxt;
  logic [7:0]    last_r, last_nxt;
  logic [FW-1:0] idx_r, idx_nxt;
  logic [FW-1:0] end_r, end_nxt;
  logic [7:0]    acc_r, acc_nxt;
  logic          neg_r, neg_nxt;
  logic          digit_ph_r, digit_ph_nxt;
  logic          sel_b_r, sel_b_nxt;
  logic [7:0]    corr_a_r, corr_b_r;
  logic [7:0]    reading_a_r, reading_a_nxt;
  logic [7:0]    reading_b_r, reading_b_nxt;
  logic          res_valid_r, res_valid_nxt;
  result_t       res_r, res_nxt;

  logic          can_emit;
  logic          etx_in;
  logic          ck_ok;
  logic          start_parse;
  logic          ram_we;
  logic [7:0]    rd_data;
  logic          is_blank, is_digit, is_sign, stop;
  logic [7:0]    acc_step;
  logic [FW-1:0] idx_inc;
  logic [7:0]    val, corr, new_val;

  stdf_ram #(
    .WIDTH (8),
    .DEPTH (PAYLOAD_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_r[AW-1:0]),
    .wdata (q_head.data),
    .raddr (idx_r[AW-1:0]),
    .rdata (rd_data)
  );

  assign can_emit = !res_valid_r || res_ready;
  assign etx_in   = (q_head.kind == KIND_ETX) && in_frame_r;
  // last stored byte against the sum of the ones before it
  assign ck_ok    = ((sum_r - last_r) == last_r);
  assign start_parse = etx_in && (fill_r != '0) && ck_ok && (fill_r >= FILL_TWO) &&
                       ((first_r == ID_A) || (first_r == ID_B));
  assign q_pop    = (state_r == ST_IDLE) && q_valid && can_emit;
  assign ram_we   = q_pop && (q_head.kind == KIND_DATA) && in_frame_r && (fill_r < FILL_MAX);

  // character decode for the parse walk
  always_comb begin
    is_blank = (rd_data == CHR_SPACE) || ((rd_data >= CHR_TAB) && (rd_data <= CHR_CR));
    is_digit = (rd_data >= CHR_ZERO) && (rd_data <= CHR_NINE);
    is_sign  = (rd_data == CHR_PLUS) || (rd_data == CHR_MINUS);
    acc_step = {acc_r[4:0], 3'b000} + {acc_r[6:0], 1'b0} + (rd_data - CHR_ZERO);
    idx_inc  = idx_r + FILL_ONE;
    if (digit_ph_r) begin
      stop = !is_digit;
    end else begin
      stop = !(is_blank || is_sign || is_digit);
    end
    val     = neg_r ? (8'd0 - acc_r) : acc_r;
    corr    = sel_b_r ? corr_b_r : corr_a_r;
    new_val = (val == 8'd0) ? 8'd0 : (val + corr);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_pop && start_parse) begin
          state_nxt = (fill_r == FILL_TWO) ? ST_FINISH : ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (stop || (idx_inc == end_r)) begin
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_READ;
        end
      end
      ST_FINISH: begin
        if (can_emit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // datapath and result
  always_comb begin
    in_frame_nxt  = in_frame_r;
    fill_nxt      = fill_r;
    sum_nxt       = sum_r;
    first_nxt     = first_r;
    last_nxt      = last_r;
    idx_nxt       = idx_r;
    end_nxt       = end_r;
    acc_nxt       = acc_r;
    neg_nxt       = neg_r;
    digit_ph_nxt  = digit_ph_r;
    sel_b_nxt     = sel_b_r;
    reading_a_nxt = reading_a_r;
    reading_b_nxt = reading_b_r;
    res_valid_nxt = res_valid_r && !res_ready;
    res_nxt       = res_r;
    case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          res_valid_nxt = !start_parse;
          res_nxt       = '{status: STAT_NONE, restart: 1'b0, updated: UPD_NONE};
          if (etx_in) begin
            in_frame_nxt    = 1'b0;
            fill_nxt        = '0;
            res_nxt.restart = 1'b1;
            if (fill_r == '0) begin
              res_nxt.status = STAT_EMPTY;
            end else if (!ck_ok) begin
              res_nxt.status = STAT_CHECKSUM;
            end else begin
              res_nxt.status = STAT_GOOD;
            end
            idx_nxt      = FILL_ONE;
            end_nxt      = fill_r - FILL_ONE;
            acc_nxt      = 8'd0;
            neg_nxt      = 1'b0;
            digit_ph_nxt = 1'b0;
            sel_b_nxt    = (first_r == ID_B);
          end else if (q_head.kind == KIND_STX) begin
            in_frame_nxt = 1'b1;
            sum_nxt      = 8'd0;
            fill_nxt     = '0;
          end else if (in_frame_r) begin
            if (fill_r < FILL_MAX) begin
              fill_nxt = fill_r + FILL_ONE;
              sum_nxt  = sum_r + q_head.data;
              last_nxt = q_head.data;
              if (fill_r == '0) begin
                first_nxt = q_head.data;
              end
            end else begin
              in_frame_nxt    = 1'b0;
              fill_nxt        = '0;
              res_nxt.status  = STAT_OVERFLOW;
              res_nxt.restart = 1'b1;
            end
          end
        end
      end
      ST_EVAL: begin
        idx_nxt = idx_inc;
        if (!stop) begin
          if (!digit_ph_r && is_sign) begin
            neg_nxt      = (rd_data == CHR_MINUS);
            digit_ph_nxt = 1'b1;
          end else if (is_digit) begin
            acc_nxt      = acc_step;
            digit_ph_nxt = 1'b1;
          end
        end
      end
      ST_FINISH: begin
        if (can_emit) begin
          res_valid_nxt = 1'b1;
          if (sel_b_r) begin
            reading_b_nxt = new_val;
            res_nxt.updated = UPD_B;
          end else begin
            reading_a_nxt = new_val;
            res_nxt.updated = UPD_A;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_frame_r  <= 1'b0;
      fill_r      <= '0;
      sum_r       <= 8'd0;
      reading_a_r <= 8'd0;
      reading_b_r <= 8'd0;
      res_valid_r <= 1'b0;
      corr_a_r    <= CORR_RESET;
      corr_b_r    <= CORR_RESET;
    end else begin
      state_r     <= state_nxt;
      in_frame_r  <= in_frame_nxt;
      fill_r      <= fill_nxt;
      sum_r       <= sum_nxt;
      reading_a_r <= reading_a_nxt;
      reading_b_r <= reading_b_nxt;
      res_valid_r <= res_valid_nxt;
      if (cfg_we && (cfg_index == CFG_CORR_A)) begin
        corr_a_r <= cfg_data;
      end
      if (cfg_we && (cfg_index == CFG_CORR_B)) begin
        corr_b_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    first_r    <= first_nxt;
    last_r     <= last_nxt;
    idx_r      <= idx_nxt;
    end_r      <= end_nxt;
    acc_r      <= acc_nxt;
    neg_r      <= neg_nxt;
    digit_ph_r <= digit_ph_nxt;
    sel_b_r    <= sel_b_nxt;
    res_r      <= res_nxt;
  end

  // readings only move when a result is loaded, so they track the held result
  assign res_valid = res_valid_r;
  assign res       = res_r;
  assign reading_a = reading_a_r;
  assign reading_b = reading_b_r;

endmodule
`default_nettype wire

[hdl/sensor_telegram_deframer.sv]
`default_nettype none
// channel  | ports                                              | transfer when
// ---------+----------------------------------------------------+------------------------
// input    | in_valid, in_ready, in_rx_byte                     | in_valid & in_ready
// result   | out_valid, out_ready, out_frame_status, out_restart_fifo,
//          | out_updated_sensor, out_sensor_a_value, out_sensor_b_value | out_valid & out_ready
// config   | cfg_we, cfg_index, cfg_data                        | cfg_we
//
// every byte gives one result; most bytes are handled in the back end's idle state
// a good A or B frame walks the text one stored byte at a time (registered
// store read, then decode), stopping at the checksum or at a byte that ends the number
// a two-entry queue takes bytes while the back end parses or the result waits
// synchronous active-low reset clears frame state and readings and sets both corrections to CORR_RESET
module sensor_telegram_deframer #(
  parameter int PAYLOAD_DEPTH = 6
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        in_rx_byte,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [2:0]             out_frame_status,
  output logic                   out_restart_fifo,
  output logic [1:0]             out_updated_sensor,
  output logic signed [7:0]      out_sensor_a_value,
  output logic signed [7:0]      out_sensor_b_value,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [7:0]        cfg_data
);
  import stdf_pkg::*;

  logic       q_valid;
  q_entry_t   q_head;
  logic       q_pop;
  result_t    res;
  logic [7:0] reading_a;
  logic [7:0] reading_b;

  stdf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop)
  );

  stdf_back #(
    .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res       (res),
    .reading_a (reading_a),
    .reading_b (reading_b)
  );

  assign out_frame_status   = res.status;
  assign out_restart_fifo   = res.restart;
  assign out_updated_sensor = res.updated;
  assign out_sensor_a_value = reading_a;
  assign out_sensor_b_value = reading_b;

endmodule
`default_nettype wire

[verif/deframer_outcome_checker.sv]
`timescale 1ns / 1ps
module deframer_outcome_checker
  import stdf_pkg::*;
#(
  parameter int PAYLOAD_DEPTH = 6
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [2:0] out_frame_status,
  input  logic       out_restart_fifo,
  input  logic [1:0] out_updated_sensor,
  input  logic [7:0] out_sensor_a_value,
  input  logic [7:0] out_sensor_b_value,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  output int         pending,
  output int         fail_count
);

  typedef struct packed {
    status_t    status;
    logic       restart;
    upd_t       updated;
    logic [7:0] reading_a;
    logic [7:0] reading_b;
  } frame_outcome_t;

  frame_outcome_t outcome_q[$];
  frame_outcome_t want;

  logic       frame_open;
  int         stored;
  logic [7:0] sum_acc;
  logic [7:0] store_mem [PAYLOAD_DEPTH];
  logic [7:0] reading_a;
  logic [7:0] reading_b;
  logic [7:0] corr_a;
  logic [7:0] corr_b;
  int         mismatches = 0;
  int         results_seen = 0;

  function automatic logic is_blank(input logic [7:0] c);
    return c == CHR_SPACE || (c >= CHR_TAB && c <= CHR_CR);
  endfunction

  // text after the id byte up to the checksum, wraps mod 256
  function automatic logic [7:0] decode_text(input int last);
    int         i;
    logic       neg;
    logic [7:0] acc;
    i = 1;
    neg = 1'b0;
    acc = 8'h00;
    while (i < last && is_blank(store_mem[i])) i = i + 1;
    if (i < last && (store_mem[i] == CHR_PLUS || store_mem[i] == CHR_MINUS)) begin
      neg = (store_mem[i] == CHR_MINUS);
      i = i + 1;
    end
    while (i < last && store_mem[i] >= CHR_ZERO && store_mem[i] <= CHR_NINE) begin
      acc = acc * 8'd10 + (store_mem[i] - CHR_ZERO);
      i = i + 1;
    end
    if (neg) begin
      acc = 8'h00 - acc;
    end
    return acc;
  endfunction

  function automatic logic [7:0] with_offset(input logic [7:0] v, input logic [7:0] corr);
    if (v == 8'h00) begin
      return 8'h00;
    end
    return v + corr;
  endfunction

  function automatic frame_outcome_t deframe_byte(input logic [7:0] b);
    frame_outcome_t r;
    int             last;
    logic [7:0]     ck;
    logic [7:0]     rest;
    r.status = STAT_NONE;
    r.restart = 1'b0;
    r.updated = UPD_NONE;
    if (b == BYTE_ETX && frame_open) begin
      r.restart = 1'b1;
      if (stored == 0) begin
        r.status = STAT_EMPTY;
      end else begin
        last = stored - 1;
        ck = store_mem[last];
        rest = sum_acc - ck;
        if (rest == ck) begin
          r.status = STAT_GOOD;
          // a lone byte is only the checksum, so there is no id
          if (last >= 1) begin
            if (store_mem[0] == ID_A) begin
              reading_a = with_offset(decode_text(last), corr_a);
              r.updated = UPD_A;
            end else if (store_mem[0] == ID_B) begin
              reading_b = with_offset(decode_text(last), corr_b);
              r.updated = UPD_B;
            end
          end
        end else begin
          r.status = STAT_CHECKSUM;
        end
      end
      frame_open = 1'b0;
      stored = 0;
    end else if (b == BYTE_STX) begin
      frame_open = 1'b1;
      sum_acc = 8'h00;
      stored = 0;
    end else if (frame_open) begin
      if (stored < PAYLOAD_DEPTH) begin
        store_mem[stored] = b;
        stored = stored + 1;
        sum_acc = sum_acc + b;
      end else begin
        r.status = STAT_OVERFLOW;
        r.restart = 1'b1;
        frame_open = 1'b0;
        stored = 0;
      end
    end
    r.reading_a = reading_a;
    r.reading_b = reading_b;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches = mismatches + 1;
    $display("%0t mismatch at result %0d: %s", $realtime, results_seen, what);
  endtask

  task automatic compare_field(input string name, input logic [7:0] got,
                               input logic [7:0] wanted);
    if (got !== wanted) begin
      report_mismatch($sformatf("%s got 0x%02h expected 0x%02h", name, got, wanted));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      frame_open = 1'b0;
      stored = 0;
      sum_acc = 8'h00;
      reading_a = 8'h00;
      reading_b = 8'h00;
      corr_a = CORR_RESET;
      corr_b = CORR_RESET;
      outcome_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_CORR_A) begin
          corr_a = cfg_data;
        end else begin
          corr_b = cfg_data;
        end
      end
      if (in_valid && in_ready) begin
        outcome_q.push_back(deframe_byte(in_rx_byte));
      end
      if (out_valid && out_ready) begin
        results_seen = results_seen + 1;
        if (outcome_q.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          want = outcome_q.pop_front();
          compare_field("frame_status", 8'(out_frame_status), 8'(want.status));
          compare_field("restart_fifo", 8'(out_restart_fifo), 8'(want.restart));
          compare_field("updated_sensor", 8'(out_updated_sensor), 8'(want.updated));
          compare_field("sensor_a_value", out_sensor_a_value, want.reading_a);
          compare_field("sensor_b_value", out_sensor_b_value, want.reading_b);
        end
      end
    end
    pending <= outcome_q.size();
    fail_count <= mismatches;
  end

endmodule

[verif/tb_sensor_telegram_deframer.sv]
`timescale 1ns / 1ps
module tb_sensor_telegram_deframer;
  import stdf_pkg::*;

  localparam int PAYLOAD_DEPTH = 6;
  localparam int PHASE_BYTES = 188;
  localparam int HOLD_CYCLES = 80;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [7:0]        in_rx_byte = 8'h00;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [2:0]        out_frame_status;
  logic              out_restart_fifo;
  logic [1:0]        out_updated_sensor;
  logic signed [7:0] out_sensor_a_value;
  logic signed [7:0] out_sensor_b_value;
  logic              cfg_we = 1'b0;
  logic              cfg_index = CFG_CORR_A;
  logic [7:0]        cfg_data = 8'h00;

  int pending;
  int fail_count;

  int         gap_max = 16;
  int         stall_max = 16;
  int         hold_len = 0;
  int         bytes_sent = 0;
  int         telegrams = 0;
  logic [7:0] telegram_body[$];

  always #4 clk = ~clk;

  sensor_telegram_deframer #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_frame_status  (out_frame_status),
    .out_restart_fifo  (out_restart_fifo),
    .out_updated_sensor(out_updated_sensor),
    .out_sensor_a_value(out_sensor_a_value),
    .out_sensor_b_value(out_sensor_b_value),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  deframer_outcome_checker #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_frame_status  (out_frame_status),
    .out_restart_fifo  (out_restart_fifo),
    .out_updated_sensor(out_updated_sensor),
    .out_sensor_a_value(out_sensor_a_value),
    .out_sensor_b_value(out_sensor_b_value),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .pending           (pending),
    .fail_count        (fail_count)
  );

  // valid stays high across back-to-back transfers
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent = bytes_sent + 1;
  endtask

  task automatic send_telegram(input logic corrupt);
    logic [7:0] sum;
    logic [7:0] flip;
    sum = 8'h00;
    flip = 8'($urandom_range(1, 255));
    send_byte(BYTE_STX);
    foreach (telegram_body[i]) begin
      send_byte(telegram_body[i]);
      sum = sum + telegram_body[i];
    end
    send_byte(corrupt ? (sum ^ flip) : sum);
    send_byte(BYTE_ETX);
    telegrams = telegrams + 1;
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (b == BYTE_STX || b == BYTE_ETX);
    return b;
  endfunction

  function automatic logic [7:0] text_char();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      return CHR_ZERO + 8'($urandom_range(0, 9));
    end else if (pick < 58) begin
      return CHR_SPACE;
    end else if (pick < 63) begin
      return CHR_TAB + 8'($urandom_range(0, 4));
    end else if (pick < 69) begin
      return CHR_MINUS;
    end else if (pick < 73) begin
      return CHR_PLUS;
    end else if (pick < 78) begin
      return 8'h00;
    end
    return plain_byte();
  endfunction

  task automatic random_traffic();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    telegram_body.delete();
    if (pick < 65) begin
      if ($urandom_range(0, 9) == 0) begin
        telegram_body.push_back(plain_byte());
      end else begin
        telegram_body.push_back($urandom_range(0, 1) ? ID_A : ID_B);
      end
      n = $urandom_range(0, PAYLOAD_DEPTH - 2);
      repeat (n) telegram_body.push_back(text_char());
      send_telegram($urandom_range(0, 7) == 0);
    end else if (pick < 75) begin
      // runs past the store and gets rejected
      send_byte(BYTE_STX);
      n = $urandom_range(PAYLOAD_DEPTH + 1, PAYLOAD_DEPTH + 2);
      repeat (n) send_byte(plain_byte());
    end else if (pick < 85) begin
      send_byte(BYTE_STX);
      if ($urandom_range(0, 1)) begin
        send_byte($urandom_range(0, 1) ? 8'h00 : plain_byte());
      end
      send_byte(BYTE_ETX);
    end else begin
      n = $urandom_range(1, 6);
      repeat (n) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // drop valid, let the last transfer show up in pending, then wait for it to empty
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic load_corrections(input logic [7:0] a, input logic [7:0] b);
    cfg_we <= 1'b1;
    cfg_index <= CFG_CORR_A;
    cfg_data <= a;
    @(posedge clk);
    cfg_index <= CFG_CORR_B;
    cfg_data <= b;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // result side: random stall per transfer, or a long hold-off when asked
  initial begin
    int stall;
    @(posedge clk);
    forever begin
      if (hold_len > 0) begin
        stall = hold_len;
        hold_len = 0;
      end else begin
        stall = $urandom_range(0, stall_max);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    int directed;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // outside a frame, etx and any byte are ignored
    send_byte(BYTE_ETX);
    send_byte(8'hFF);
    // empty frame
    send_byte(BYTE_STX);
    send_byte(BYTE_ETX);
    // a lone zero byte is a good checksum with no id
    telegram_body.delete();
    send_telegram(1'b0);
    // stx reopens an open frame; blank, sign and digit for sensor A
    send_byte(BYTE_STX);
    send_byte(8'h5A);
    telegram_body.delete();
    telegram_body.push_back(ID_A);
    telegram_body.push_back(CHR_SPACE);
    telegram_body.push_back(CHR_MINUS);
    telegram_body.push_back(CHR_NINE);
    send_telegram(1'b0);
    // seventh payload byte overflows the store
    send_byte(BYTE_STX);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h80);
    send_byte(8'h7F);
    send_byte(8'h01);
    send_byte(8'h55);
    send_byte(8'hAA);
    directed = bytes_sent;

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: begin
          gap_max = 16;
          stall_max = 16;
        end
        1: begin
          load_corrections(8'h7F, 8'h80);
          gap_max = 0;
          stall_max = 0;
        end
        2: begin
          load_corrections(8'h80, 8'h7F);
          gap_max = 0;
          stall_max = 3;
          hold_len = HOLD_CYCLES;
        end
        3: begin
          load_corrections(8'h00, 8'h00);
          gap_max = 16;
          stall_max = 0;
        end
        4: begin
          load_corrections(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
          gap_max = 3;
          stall_max = 16;
        end
        default: begin
          load_corrections(8'h01, 8'hFF);
          gap_max = 16;
          stall_max = 16;
        end
      endcase
      while (bytes_sent < directed + (ph + 1) * PHASE_BYTES) random_traffic();
    end

    drain();
    repeat (2 * PAYLOAD_DEPTH + 8) @(posedge clk);
    $display("covered %0d bytes, %0d directed, %0d checksummed telegrams plus noise",
             bytes_sent, directed, telegrams);
    $display("six correction settings incl. both extremes, one %0d-cycle result hold-off",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("[sensor_telegram_deframer] OK");
    end else begin
      $display("[sensor_telegram_deframer] ERROR");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("timeout with %0d results outstanding", pending);
    $display("[sensor_telegram_deframer] ERROR");
    $finish;
  end

endmodule
